// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants for the slip frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_ESC     = 8'hDB;
	localparam logic [7:0] BYTE_ESC_END = 8'hDC;
	localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

	localparam int unsigned RESULT_CAP = 64;
	localparam logic [6:0]  MAX_STORED_RST = 7'd64;

	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_READ    = 2'd1;
	localparam logic [1:0] PH_INVALID = 2'd3;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_EVENT   = 2'd2;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_BAD_ESC   = 3'd1;
	localparam logic [2:0] EV_UNEXP_END = 3'd2;
	localparam logic [2:0] EV_SEQ       = 3'd3;
	localparam logic [2:0] EV_OVERFLOW  = 3'd4;
	localparam logic [2:0] EV_CHECKSUM  = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] frame_seq;
		logic [5:0] payload_len;
		logic [2:0] event_code;
		logic       last;
	} res_t;

endpackage

// ===== src/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr channel interfaces
// valid/ready channels for config writes, received bytes and results
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] max_stored;

	modport source (output valid, output max_stored, input ready);
	modport sink (input valid, input max_stored, output ready);
endinterface

interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data;
	logic [7:0] frame_seq;
	logic [5:0] payload_len;
	logic [2:0] event_code;
	logic       last;

	modport source (
		output valid, output kind, output data, output frame_seq,
		output payload_len, output event_code, output last, input ready
	);
	modport sink (
		input valid, input kind, input data, input frame_seq,
		input payload_len, input event_code, input last, output ready
	);
endinterface

// ===== src/slip_frame_receiver_seq_xor_check.sv =====
// ----------------------------------------------------------------------------
// slip_frame_receiver_seq_xor_check
// slip deframer with sequence number check and xor checksum
// ----------------------------------------------------------------------------
// A received byte is taken whenever the receiver is idle and the result
// register is free; a byte that causes a warning or error gives its single
// event beat in the next cycle. Payload bytes are held in a ram until the
// frame end; on a good frame end the receiver stops taking bytes and drains
// the ram, each payload byte by a ram read and then a result load, and then
// gives the frame-done beat. The checksum byte is stored but not given out.
// The drain rate is set by the registered read of the single payload ram.
// ----------------------------------------------------------------------------
module slip_frame_receiver_seq_xor_check
	import sfr_pkg::*;
#(
	parameter int STORE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_cfg_if.sink   cfg,
	sfr_in_if.sink    rx,
	sfr_out_if.source res
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [6:0] LIMIT_CAP =
		7'((STORE_DEPTH < RESULT_CAP) ? STORE_DEPTH : RESULT_CAP);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_MARK = 2'd3;

	logic [1:0] state_q;
	logic [6:0] max_stored_q;
	logic [1:0] phase_q;
	logic       esc_q;
	logic [7:0] xor_q;
	logic [7:0] exp_q;
	logic [7:0] cur_q;
	logic [6:0] fill_q;
	logic [5:0] len_q;
	logic [5:0] idx_q;
	res_t       out_q;
	logic       out_valid_q;

	logic       slot_free;
	logic       accept;
	logic [6:0] lim;

	logic       esc_n;
	logic [1:0] phase_n;
	logic [7:0] xor_n;
	logic [7:0] exp_n;
	logic [7:0] cur_n;
	logic [6:0] fill_n;
	logic [7:0] b;
	logic       is_data;
	logic [2:0] ev;
	logic       drain;
	logic       we;

	logic       ram_re;
	logic [7:0] ram_rdata;

	assign slot_free = !out_valid_q || res.ready;
	assign rx.ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;
	assign lim       = (max_stored_q > LIMIT_CAP) ? LIMIT_CAP : max_stored_q;
	assign ram_re    = (state_q == ST_RD);

	// byte handling
	always_comb begin
		esc_n   = esc_q;
		phase_n = phase_q;
		xor_n   = xor_q;
		exp_n   = exp_q;
		cur_n   = cur_q;
		fill_n  = fill_q;
		b       = rx.rx_byte;
		is_data = 1'b0;
		ev      = EV_NONE;
		drain   = 1'b0;
		we      = 1'b0;
		if (esc_q) begin
			esc_n = 1'b0;
			if (rx.rx_byte == BYTE_ESC_END) begin
				b       = BYTE_END;
				is_data = 1'b1;
			end else if (rx.rx_byte == BYTE_ESC_ESC) begin
				b       = BYTE_ESC;
				is_data = 1'b1;
			end else begin
				ev      = EV_BAD_ESC;
				phase_n = PH_INVALID;
			end
			xor_n = xor_q ^ b;
		end else if (rx.rx_byte == BYTE_ESC) begin
			esc_n = 1'b1;
		end else if (rx.rx_byte == BYTE_END) begin
			case (phase_q)
				PH_READ: begin
					if (xor_q == 8'd0 && fill_q != 7'd0) begin
						drain = 1'b1;
					end else begin
						ev    = EV_CHECKSUM;
						xor_n = 8'd0;
					end
					phase_n = PH_START;
				end
				PH_START: begin
					ev      = EV_UNEXP_END;
					phase_n = PH_INVALID;
				end
				default: begin
					xor_n   = 8'd0;
					phase_n = PH_START;
				end
			endcase
		end else begin
			xor_n   = xor_q ^ b;
			is_data = 1'b1;
		end

		if (is_data) begin
			if (phase_q == PH_START) begin
				cur_n = b;
				if (exp_q != b) begin
					ev = EV_SEQ;
				end
				exp_n   = b + 8'd1;
				fill_n  = 7'd0;
				xor_n   = b;
				phase_n = PH_READ;
			end else if (phase_q == PH_READ) begin
				if (fill_q >= lim) begin
					ev      = EV_OVERFLOW;
					phase_n = PH_INVALID;
					xor_n   = 8'd0;
				end else begin
					we     = 1'b1;
					fill_n = fill_q + 7'd1;
				end
			end
		end
	end

	sfr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && we),
		.waddr (AW'(fill_q)),
		.wdata (b),
		.re    (ram_re),
		.raddr (AW'(idx_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stored_q <= MAX_STORED_RST;
		end else if (cfg.valid) begin
			max_stored_q <= cfg.max_stored;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			esc_q   <= 1'b0;
			xor_q   <= 8'd0;
			exp_q   <= 8'd0;
			cur_q   <= 8'd0;
			fill_q  <= 7'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			xor_q   <= xor_n;
			exp_q   <= exp_n;
			cur_q   <= cur_n;
			fill_q  <= fill_n;
		end
	end

	// drain sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			len_q       <= 6'd0;
			idx_q       <= 6'd0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (ev != EV_NONE) begin
							out_valid_q <= 1'b1;
						end
						if (drain) begin
							len_q <= 6'(fill_q - 7'd1);
							idx_q <= 6'd0;
							if (fill_q == 7'd1) begin
								state_q <= ST_MARK;
							end else begin
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 6'd1;
						if ((idx_q + 6'd1) == len_q) begin
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_MARK: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && ev != EV_NONE) begin
					out_q.kind        <= KIND_EVENT;
					out_q.data        <= 8'd0;
					out_q.frame_seq   <= cur_n;
					out_q.payload_len <= 6'd0;
					out_q.event_code  <= ev;
					out_q.last        <= 1'b1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_q.kind        <= KIND_PAYLOAD;
					out_q.data        <= ram_rdata;
					out_q.frame_seq   <= cur_q;
					out_q.payload_len <= 6'd0;
					out_q.event_code  <= EV_NONE;
					out_q.last        <= 1'b0;
				end
			end
			ST_MARK: begin
				if (slot_free) begin
					out_q.kind        <= KIND_DONE;
					out_q.data        <= 8'd0;
					out_q.frame_seq   <= cur_q;
					out_q.payload_len <= len_q;
					out_q.event_code  <= EV_NONE;
					out_q.last        <= 1'b1;
				end
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = out_q.kind;
	assign res.data        = out_q.data;
	assign res.frame_seq   = out_q.frame_seq;
	assign res.payload_len = out_q.payload_len;
	assign res.event_code  = out_q.event_code;
	assign res.last        = out_q.last;

endmodule

// ===== src/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// sfr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
